FILE: hdl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared constants and types for the ADSR envelope level pipeline.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // default phase width, Q0.PHASE_BITS
    localparam int PHASE_BITS_DEF = 16;

    // byte address width of the register port
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    // control that travels with each word down the pipeline
    typedef struct packed {
        logic vld;   // stage holds a word
        logic add;   // level = base + quotient, else base - quotient
    } t_ctl;

endpackage

FILE: hdl/adsr_envelope_level.sv
// ----------------------------------------------------------------------------
// adsr_envelope_level
// Piecewise-linear ADSR envelope: phase in Q0.PHASE_BITS, level in Q1.PHASE_BITS.
// ----------------------------------------------------------------------------
// Takes one phase word per clock while o_phase_ready is high and returns one
// level word per phase word, in order, through registered stages for segment
// select, the multiply, the divider (one quotient bit per stage) and the
// output register. A two-entry output buffer lets the pipeline
// keep moving while a finished word waits; the pipeline freezes only once
// both entries are full. Registers sit on an APB port at byte addresses 0x0
// (attack end), 0x4 (decay end), 0x8 (sustain level, saturated to 1.0) and
// 0xC (release start); write them only while no word is in flight.
module adsr_envelope_level
    import adsr_pkg::*;
#(
    parameter int PHASE_BITS = PHASE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     i_phase_valid,
    output logic                     o_phase_ready,
    input  logic [PHASE_BITS-1:0]    i_phase,
    output logic                     o_level_valid,
    input  logic                     i_level_ready,
    output logic [PHASE_BITS:0]      o_level
);

    localparam int PW = PHASE_BITS;
    localparam logic [PW:0] ONE = {1'b1, {PW{1'b0}}};

    logic [PW-1:0] cfg_attack;
    logic [PW-1:0] cfg_decay;
    logic [PW:0]   cfg_sustain;
    logic [PW-1:0] cfg_release;

    t_ctl          seg_ctl;
    logic [PW:0]   seg_mul_a;
    logic [PW-1:0] seg_mul_b;
    logic [PW:0]   seg_den;
    logic [PW:0]   seg_base;

    t_ctl          mul_ctl;
    logic [2*PW:0] mul_num;
    logic [PW:0]   mul_den;
    logic [PW:0]   mul_base;

    t_ctl          div_ctl;
    logic [PW:0]   div_quo;
    logic [PW:0]   div_base;
    logic [PW:0]   fin_level;

    logic          adv;
    logic          r_out_vld;
    logic [PW:0]   r_out_level;
    logic          r_skid_vld;
    logic [PW:0]   r_skid_level;

    assign adv = ~r_skid_vld;

    adsr_cfg #(.PW(PW)) u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_attack_end    (cfg_attack),
        .o_decay_end     (cfg_decay),
        .o_sustain_level (cfg_sustain),
        .o_release_start (cfg_release)
    );

    adsr_seg #(.PW(PW)) u_seg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (adv),
        .i_vld           (i_phase_valid),
        .i_phase         (i_phase),
        .i_attack_end    (cfg_attack),
        .i_decay_end     (cfg_decay),
        .i_sustain_level (cfg_sustain),
        .i_release_start (cfg_release),
        .o_ctl           (seg_ctl),
        .o_mul_a         (seg_mul_a),
        .o_mul_b         (seg_mul_b),
        .o_den           (seg_den),
        .o_base          (seg_base)
    );

    adsr_mul #(.PW(PW)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (seg_ctl),
        .i_mul_a (seg_mul_a),
        .i_mul_b (seg_mul_b),
        .i_den   (seg_den),
        .i_base  (seg_base),
        .o_ctl   (mul_ctl),
        .o_num   (mul_num),
        .o_den   (mul_den),
        .o_base  (mul_base)
    );

    adsr_div #(.PW(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_ctl   (mul_ctl),
        .i_num   (mul_num),
        .i_den   (mul_den),
        .i_base  (mul_base),
        .o_ctl   (div_ctl),
        .o_quo   (div_quo),
        .o_base  (div_base)
    );

    // attack adds to zero; decay, sustain and release subtract from base
    assign fin_level = div_ctl.add ? (div_base + div_quo) : (div_base - div_quo);

    // output register plus skid entry; pipeline stalls only when skid is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_level_ready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || i_level_ready) begin
            r_out_vld <= div_ctl.vld;
        end else if (div_ctl.vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_level_ready) begin
                r_out_level <= r_skid_level;
            end
        end else if (!r_out_vld || i_level_ready) begin
            r_out_level <= fin_level;
        end else begin
            r_skid_level <= fin_level;
        end
    end

    assign o_phase_ready = adv;
    assign o_level_valid = r_out_vld;
    assign o_level       = r_out_level;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry full while output register empty");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_level <= ONE))
        else $error("level above full scale");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_level_ready && !r_skid_vld && div_ctl.vld) |=> r_skid_vld)
        else $error("stalled word not caught by skid entry");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && i_level_ready) |=> (!r_skid_vld && r_out_vld))
        else $error("skid entry did not move to output register");

endmodule

FILE: hdl/adsr_cfg.sv
// ----------------------------------------------------------------------------
// adsr_cfg
// APB register file: attack end, decay end, sustain level, release start.
// ----------------------------------------------------------------------------
module adsr_cfg
    import adsr_pkg::*;
#(
    parameter int PW = PHASE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output logic [PW-1:0]            o_attack_end,
    output logic [PW-1:0]            o_decay_end,
    output logic [PW:0]              o_sustain_level,
    output logic [PW-1:0]            o_release_start
);

    // reset points at 0.1, 0.3, 0.2 and 0.7 of full scale, rounded
    localparam longint unsigned ONE_I = longint'(1) << PW;
    localparam longint unsigned RST_A = (ONE_I * 1 + 5) / 10;
    localparam longint unsigned RST_D = (ONE_I * 3 + 5) / 10;
    localparam longint unsigned RST_S = (ONE_I * 2 + 5) / 10;
    localparam longint unsigned RST_R = (ONE_I * 7 + 5) / 10;

    logic [PW-1:0] r_attack;
    logic [PW-1:0] r_decay;
    logic [PW:0]   r_sustain;
    logic [PW-1:0] r_release;
    logic          wr_en;
    logic [1:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= PW'(RST_A);
            r_decay   <= PW'(RST_D);
            r_sustain <= (PW + 1)'(RST_S);
            r_release <= PW'(RST_R);
        end else if (wr_en) begin
            case (idx)
                REG_ATTACK:  r_attack  <= pwdata[PW-1:0];
                REG_DECAY:   r_decay   <= pwdata[PW-1:0];
                REG_SUSTAIN: r_sustain <= pwdata[PW:0];
                REG_RELEASE: r_release <= pwdata[PW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_ATTACK:  prdata = CFG_DATA_BITS'(r_attack);
            REG_DECAY:   prdata = CFG_DATA_BITS'(r_decay);
            REG_SUSTAIN: prdata = CFG_DATA_BITS'(r_sustain);
            REG_RELEASE: prdata = CFG_DATA_BITS'(r_release);
            default:     prdata = '0;
        endcase
    end

    assign o_attack_end    = r_attack;
    assign o_decay_end     = r_decay;
    assign o_sustain_level = r_sustain;
    assign o_release_start = r_release;

endmodule

FILE: hdl/adsr_seg.sv
// ----------------------------------------------------------------------------
// adsr_seg
// First stage: picks the segment and sets up multiplier, divisor and base.
// ----------------------------------------------------------------------------
module adsr_seg
    import adsr_pkg::*;
#(
    parameter int PW = PHASE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [PW-1:0] i_phase,
    input  logic [PW-1:0] i_attack_end,
    input  logic [PW-1:0] i_decay_end,
    input  logic [PW:0]   i_sustain_level,
    input  logic [PW-1:0] i_release_start,
    output t_ctl          o_ctl,
    output logic [PW:0]   o_mul_a,
    output logic [PW-1:0] o_mul_b,
    output logic [PW:0]   o_den,
    output logic [PW:0]   o_base
);

    localparam logic [PW:0] ONE = {1'b1, {PW{1'b0}}};
    localparam logic [PW:0] DEN_ONE = (PW + 1)'(1);

    logic [PW:0]   s_sat;
    logic [PW:0]   n_mul_a;
    logic [PW-1:0] n_mul_b;
    logic [PW:0]   n_den;
    logic [PW:0]   n_base;
    logic          n_add;

    t_ctl          r_ctl;
    logic [PW:0]   r_mul_a;
    logic [PW-1:0] r_mul_b;
    logic [PW:0]   r_den;
    logic [PW:0]   r_base;

    assign s_sat = (i_sustain_level > ONE) ? ONE : i_sustain_level;

    // sustain and zero attack run through the divider as 0 / 1
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        n_den   = DEN_ONE;
        n_base  = s_sat;
        n_add   = 1'b0;
        if (i_phase <= i_attack_end) begin
            n_base = '0;
            n_add  = 1'b1;
            if (i_attack_end != '0) begin
                n_mul_a = ONE;
                n_mul_b = i_phase;
                n_den   = {1'b0, i_attack_end};
            end
        end else if (i_phase <= i_decay_end) begin
            n_mul_a = ONE - s_sat;
            n_mul_b = i_phase - i_attack_end;
            n_den   = {1'b0, i_decay_end - i_attack_end};
            n_base  = ONE;
        end else if (i_phase > i_release_start) begin
            n_mul_a = s_sat;
            n_mul_b = i_phase - i_release_start;
            n_den   = ONE - {1'b0, i_release_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.vld <= i_vld;
            r_ctl.add <= n_add;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mul_a <= n_mul_a;
            r_mul_b <= n_mul_b;
            r_den   <= n_den;
            r_base  <= n_base;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_mul_a = r_mul_a;
    assign o_mul_b = r_mul_b;
    assign o_den   = r_den;
    assign o_base  = r_base;

endmodule

FILE: hdl/adsr_mul.sv
// ----------------------------------------------------------------------------
// adsr_mul
// Second stage: forms the dividend as a registered product.
// ----------------------------------------------------------------------------
module adsr_mul
    import adsr_pkg::*;
#(
    parameter int PW = PHASE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_ctl             i_ctl,
    input  logic [PW:0]      i_mul_a,
    input  logic [PW-1:0]    i_mul_b,
    input  logic [PW:0]      i_den,
    input  logic [PW:0]      i_base,
    output t_ctl             o_ctl,
    output logic [2*PW:0]    o_num,
    output logic [PW:0]      o_den,
    output logic [PW:0]      o_base
);

    logic [2*PW:0] prod;
    t_ctl          r_ctl;
    logic [2*PW:0] r_num;
    logic [PW:0]   r_den;
    logic [PW:0]   r_base;

    assign prod = i_mul_a * i_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num  <= prod;
            r_den  <= i_den;
            r_base <= i_base;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_num  = r_num;
    assign o_den  = r_den;
    assign o_base = r_base;

endmodule

FILE: hdl/adsr_div.sv
// ----------------------------------------------------------------------------
// adsr_div
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// The quotient never exceeds full scale, so PW+1 stages cover it.
// ----------------------------------------------------------------------------
module adsr_div
    import adsr_pkg::*;
#(
    parameter int PW = PHASE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [2*PW:0] i_num,
    input  logic [PW:0]   i_den,
    input  logic [PW:0]   i_base,
    output t_ctl          o_ctl,
    output logic [PW:0]   o_quo,
    output logic [PW:0]   o_base
);

    localparam int NW = 2 * PW + 1;

    t_ctl          r_ctl  [0:PW];
    logic [PW:0]   r_quo  [0:PW];
    logic [PW:0]   r_den  [0:PW];
    logic [PW:0]   r_base [0:PW];
    logic [NW-1:0] r_rem  [0:PW-1];

    for (genvar j = 0; j <= PW; j++) begin : g_stage
        localparam int BIT = PW - j;

        t_ctl          ctl_in;
        logic [NW-1:0] rem_in;
        logic [PW:0]   quo_in;
        logic [PW:0]   den_in;
        logic [PW:0]   base_in;
        logic [NW-1:0] sh;
        logic          ge;
        logic [PW:0]   n_quo;

        if (j == 0) begin : g_first
            assign ctl_in  = i_ctl;
            assign rem_in  = i_num;
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign base_in = i_base;
        end else begin : g_next
            assign ctl_in  = r_ctl[j-1];
            assign rem_in  = r_rem[j-1];
            assign quo_in  = r_quo[j-1];
            assign den_in  = r_den[j-1];
            assign base_in = r_base[j-1];
        end

        assign sh = NW'(den_in) << BIT;
        assign ge = (rem_in >= sh);

        always_comb begin
            n_quo      = quo_in;
            n_quo[BIT] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[j] <= '0;
            end else if (i_en) begin
                r_ctl[j] <= ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j]  <= n_quo;
                r_den[j]  <= den_in;
                r_base[j] <= base_in;
            end
        end

        // last stage needs no remainder
        if (j < PW) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= ge ? (rem_in - sh) : rem_in;
                end
            end
        end
    end

    assign o_ctl  = r_ctl[PW];
    assign o_quo  = r_quo[PW];
    assign o_base = r_base[PW];

endmodule
